// ===== hdl/full_linear_convolution_core_macros.svh =====
// Assertion macros used by the convolution core sequencer (flc_ctrl).
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef FULL_LINEAR_CONVOLUTION_CORE_MACROS_SVH
`define FULL_LINEAR_CONVOLUTION_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Plain property, disabled while reset is asserted.
`define FLC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Same-cycle implication.
`define FLC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`else
`define FLC_ASSERT(lbl, clk, rstn, prop, msg)
`define FLC_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== hdl/flc_pkg.sv =====
// Types and constants of the convolution core.
// Used by flc_ctrl, flc_datapath and full_linear_convolution_core.
package flc_pkg;

  localparam int KL_W = 5;
  localparam logic [KL_W-1:0] KL_RESET = 5'd16;
  localparam int TAP_W = 16;
  localparam int OUT_W = 36;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [3:0]        tap_index;
    logic signed [15:0] sample_value;
    logic              last_sample;
  } req_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] conv_out;
    logic                    last_output;
  } rsp_t;

  typedef struct packed {
    logic load_tap;
    logic shift_sample;
    logic shift_zero;
    logic clear_hist;
    logic issue;
    logic first_term;
    logic last_term;
    logic push;
    logic last_out;
  } cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/full_linear_convolution_core.sv =====
// Top level of the full linear convolution core.
// Depends on flc_pkg, flc_ctrl and flc_datapath.
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o, in_req_i): func = load writes one
//    Q1.15 tap at tap_index and gives no result; func = sample shifts one
//    sample into the delay line and gives one result. A sample request with
//    last_sample set also flushes the m-1 tail outputs, flags the final one
//    with last_output and clears the delay line for the next vector.
//  - Output channel (out_valid_o/out_ready_i, out_rsp_o): exact 36-bit sum.
//  - cfg_we_i/cfg_wdata_i write kernel_length (m); write it only while idle.
//  - A load request writes the tap store as it is taken. Each output runs the
//    single multiply-accumulate unit once per tap: m MAC issues, then the
//    memory read, product and accumulate stages; a last sample gives its m
//    outputs one after another.
//  - The output register lets a new request be taken while a result waits;
//    a stalled receiver holds the next output in the accumulator, and no
//    further request is taken until that output has moved on.
//  - Reset: taps and delay line read as zero, m = 16, both channels empty.
module full_linear_convolution_core #(
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  flc_pkg::req_t            in_req_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output flc_pkg::rsp_t            out_rsp_o,
  input  logic                     cfg_we_i,
  input  logic [flc_pkg::KL_W-1:0] cfg_wdata_i
);

  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  flc_pkg::cmd_t    cmd;
  flc_pkg::status_t st;
  logic [IDX_W-1:0] rd_idx;

  // sequencer: owns kernel_length, tap and tail counters
  flc_ctrl #(
    .MAX_TAPS(MAX_TAPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .st_i       (st),
    .cmd_o      (cmd),
    .rd_idx_o   (rd_idx)
  );

  // memories, MAC pipeline and output register
  flc_datapath #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .cmd_i      (cmd),
    .rd_idx_i   (rd_idx),
    .st_o       (st),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

// ===== hdl/flc_ctrl.sv =====
// Sequencer of the convolution core: request intake, MAC issue, tail flush.
// Depends on flc_pkg and full_linear_convolution_core_macros.svh.
`include "full_linear_convolution_core_macros.svh"

module flc_ctrl #(
  parameter int MAX_TAPS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  flc_pkg::req_t                in_req_i,
  input  logic                         cfg_we_i,
  input  logic [flc_pkg::KL_W-1:0]     cfg_wdata_i,
  input  flc_pkg::status_t             st_i,
  output flc_pkg::cmd_t                cmd_o,
  output logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] rd_idx_o
);

  localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int MW    = (CNT_W > flc_pkg::KL_W) ? CNT_W : flc_pkg::KL_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]               state_q, state_d;
  logic [flc_pkg::KL_W-1:0] kl_q;
  logic [CNT_W-1:0]         m_q, m_d, i_q, i_d, t_q, t_d;
  logic                     last_q, last_d;
  logic [MW-1:0]            kl_ext;
  logic [CNT_W-1:0]         m_eff;
  logic                     final_out;

  // taps in use: zero counts as one, saturate at the store depth
  always_comb begin
    kl_ext = MW'(kl_q);
    if (kl_ext == '0) begin
      m_eff = CNT_W'(1);
    end else if (kl_ext > MW'(MAX_TAPS)) begin
      m_eff = CNT_W'(MAX_TAPS);
    end else begin
      m_eff = CNT_W'(kl_ext);
    end
  end

  assign final_out = (t_q == (m_q - CNT_W'(1)));
  assign rd_idx_o  = i_q[IDX_W-1:0];

  always_comb begin
    state_d    = state_q;
    m_d        = m_q;
    i_d        = i_q;
    t_d        = t_q;
    last_d     = last_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.func == flc_pkg::FUNC_LOAD) begin
            cmd_o.load_tap = 1'b1;
          end else begin
            cmd_o.shift_sample = 1'b1;
            last_d  = in_req_i.last_sample;
            m_d     = m_eff;
            i_d     = '0;
            t_d     = '0;
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        cmd_o.issue      = 1'b1;
        cmd_o.first_term = (i_q == '0);
        cmd_o.last_term  = (i_q == (m_q - CNT_W'(1)));
        if (cmd_o.last_term) begin
          state_d = S_WAIT;
        end else begin
          i_d = i_q + CNT_W'(1);
        end
      end
      S_WAIT: begin
        if (st_i.acc_done && st_i.out_free) begin
          cmd_o.push     = 1'b1;
          cmd_o.last_out = last_q && final_out;
          if (last_q && !final_out) begin
            // flush: shift a zero in and compute the next tail output
            cmd_o.shift_zero = 1'b1;
            t_d     = t_q + CNT_W'(1);
            i_d     = '0;
            state_d = S_RUN;
          end else begin
            cmd_o.clear_hist = last_q;
            state_d          = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kl_q    <= flc_pkg::KL_RESET;
      m_q     <= CNT_W'(1);
      i_q     <= '0;
      t_q     <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      i_q     <= i_d;
      t_q     <= t_d;
      last_q  <= last_d;
      if (cfg_we_i) begin
        kl_q <= cfg_wdata_i;
      end
    end
  end

  `FLC_ASSERT_IMPL(a_push_needs_slot, clk_i, rst_ni, cmd_o.push, st_i.out_free, "push into busy output")
  `FLC_ASSERT_IMPL(a_first_after_drain, clk_i, rst_ni, cmd_o.issue && cmd_o.first_term, !st_i.acc_done, "new sum over unsent result")
  `FLC_ASSERT_IMPL(a_counts_in_range, clk_i, rst_ni, state_q != S_IDLE, (i_q < m_q) && (t_q < m_q), "counter past tap count")
  `FLC_ASSERT(a_flush_reissues, clk_i, rst_ni, cmd_o.shift_zero |=> (state_q == S_RUN), "flush did not restart MAC")
  `FLC_ASSERT_IMPL(a_clear_on_final, clk_i, rst_ni, cmd_o.clear_hist, cmd_o.push && cmd_o.last_out, "history cleared early")

endmodule

// ===== hdl/flc_datapath.sv =====
// Datapath of the convolution core: tap and history memories, MAC pipeline,
// output register. Depends on flc_pkg; driven by flc_ctrl commands.
module flc_datapath #(
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  flc_pkg::req_t        in_req_i,
  input  flc_pkg::cmd_t        cmd_i,
  input  logic [((MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1)-1:0] rd_idx_i,
  output flc_pkg::status_t     st_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output flc_pkg::rsp_t        out_rsp_o
);

  localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int AW     = IDX_W + 1;
  localparam int SB     = SAMPLE_BITS;
  localparam int PROD_W = flc_pkg::TAP_W + SB;
  localparam int EXT_W  = (PROD_W > flc_pkg::OUT_W) ? PROD_W : flc_pkg::OUT_W;

  logic signed [flc_pkg::TAP_W-1:0] coef_mem [MAX_TAPS];
  logic signed [SB-1:0]             hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]              coef_vld_q, hist_vld_q;
  logic [IDX_W-1:0]                 wptr_q, wptr_inc;

  logic [SB+15:0]       samp_wide;
  logic signed [SB-1:0] samp;
  logic [IDX_W+3:0]     tap_wide;
  logic [IDX_W-1:0]     tap_addr;
  logic                 tap_we;
  logic [AW-1:0]        h_sum;
  logic [IDX_W-1:0]     h_addr;

  logic signed [flc_pkg::TAP_W-1:0] coef_rd_q, coef_val;
  logic signed [SB-1:0]             hist_rd_q, hist_val;
  logic                             coef_ok_q, hist_ok_q;
  logic                             s1_v_q, s1_first_q, s1_lt_q;
  logic                             s2_v_q, s2_first_q, s2_lt_q;
  logic signed [PROD_W-1:0]         prod_q;
  logic signed [EXT_W-1:0]          prod_ext;
  logic signed [flc_pkg::OUT_W-1:0] prod_w, acc_q;
  logic                             acc_done_q;
  logic                             out_valid_q;
  flc_pkg::rsp_t                    out_rsp_q;

  // sample taken from the low SAMPLE_BITS of the field, zero-filled above it
  assign samp_wide = {{SB{1'b0}}, in_req_i.sample_value};
  assign samp      = samp_wide[SB-1:0];
  assign tap_wide  = {{IDX_W{1'b0}}, in_req_i.tap_index};
  assign tap_addr  = tap_wide[IDX_W-1:0];
  assign tap_we    = cmd_i.load_tap && (int'(in_req_i.tap_index) < MAX_TAPS);

  assign wptr_inc = (wptr_q == IDX_W'(MAX_TAPS - 1)) ? '0 : (wptr_q + IDX_W'(1));

  // history entry i sits i slots behind the write pointer
  always_comb begin
    h_sum = {1'b0, wptr_q} + AW'(MAX_TAPS) - {1'b0, rd_idx_i};
    if (wptr_q >= rd_idx_i) begin
      h_addr = wptr_q - rd_idx_i;
    end else begin
      h_addr = h_sum[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      coef_mem[tap_addr] <= in_req_i.sample_value;
    end
    if (cmd_i.shift_sample) begin
      hist_mem[wptr_inc] <= samp;
    end
    if (cmd_i.issue) begin
      coef_rd_q <= coef_mem[rd_idx_i];
      hist_rd_q <= hist_mem[h_addr];
      coef_ok_q <= coef_vld_q[rd_idx_i];
      hist_ok_q <= hist_vld_q[h_addr];
    end
  end

  assign coef_val = coef_ok_q ? coef_rd_q : '0;
  assign hist_val = hist_ok_q ? hist_rd_q : '0;
  assign prod_ext = EXT_W'(prod_q);
  assign prod_w   = prod_ext[flc_pkg::OUT_W-1:0];

  // payload pipeline registers
  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      prod_q <= coef_val * hist_val;
    end
    if (s2_v_q) begin
      acc_q <= s2_first_q ? prod_w : (acc_q + prod_w);
    end
    if (cmd_i.push) begin
      out_rsp_q.conv_out    <= acc_q;
      out_rsp_q.last_output <= cmd_i.last_out;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q  <= '0;
      hist_vld_q  <= '0;
      wptr_q      <= '0;
      s1_v_q      <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_lt_q     <= 1'b0;
      s2_v_q      <= 1'b0;
      s2_first_q  <= 1'b0;
      s2_lt_q     <= 1'b0;
      acc_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tap_we) begin
        coef_vld_q[tap_addr] <= 1'b1;
      end
      if (cmd_i.shift_sample) begin
        wptr_q               <= wptr_inc;
        hist_vld_q[wptr_inc] <= 1'b1;
      end else if (cmd_i.shift_zero) begin
        wptr_q               <= wptr_inc;
        hist_vld_q[wptr_inc] <= 1'b0;
      end else if (cmd_i.clear_hist) begin
        hist_vld_q <= '0;
      end
      s1_v_q     <= cmd_i.issue;
      s1_first_q <= cmd_i.first_term;
      s1_lt_q    <= cmd_i.last_term;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_lt_q    <= s1_lt_q;
      if (s2_v_q && s2_lt_q) begin
        acc_done_q <= 1'b1;
      end else if (cmd_i.push) begin
        acc_done_q <= 1'b0;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign st_o.acc_done = acc_done_q;
  assign st_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign out_rsp_o     = out_rsp_q;

endmodule

// ===== bench/full_linear_convolution_core_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for full_linear_convolution_core: tap loads, sample vectors, tail flush.
// Depends on flc_pkg and the core RTL; expected sums come from a predictor class in this file.
module full_linear_convolution_core_tb;

  localparam int MAX_TAPS      = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int CLK_PERIOD    = 10;
  // Settle time after the queue drains, sized for two outputs at the largest tap count.
  localparam int SETTLE_CYCLES = 2 * (MAX_TAPS + 3);
  localparam int LONG_HOLD     = 300;   // receiver back-pressure burst
  localparam int QUIET_LIMIT   = 2000;  // cycles with no handshake before giving up
  localparam int RANDOM_ITEMS  = 185;

  // Predicts the convolution outputs and checks them in order.
  class conv_scoreboard;
    logic signed [flc_pkg::TAP_W-1:0] taps [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]    delay_line [MAX_TAPS];
    logic [flc_pkg::KL_W-1:0]         kernel_len;
    flc_pkg::rsp_t                    expected_sums [$];
    int errors     = 0;
    int n_requests = 0;
    int n_loads    = 0;
    int n_vectors  = 0;
    int n_results  = 0;

    function new();
      foreach (taps[i]) begin
        taps[i]       = '0;
        delay_line[i] = '0;
      end
      kernel_len = flc_pkg::KL_RESET;
    endfunction

    // Zero length acts as one tap, anything above the store saturates.
    function int taps_used();
      if (kernel_len == 0) return 1;
      if (kernel_len > MAX_TAPS) return MAX_TAPS;
      return int'(kernel_len);
    endfunction

    function logic signed [flc_pkg::OUT_W-1:0] fir_sum(int m);
      longint acc;
      acc = 0;
      for (int i = 0; i < m; i++) acc += longint'(taps[i]) * longint'(delay_line[i]);
      return acc[flc_pkg::OUT_W-1:0];
    endfunction

    function void shift_in(logic signed [SAMPLE_BITS-1:0] s);
      for (int i = MAX_TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
      delay_line[0] = s;
    endfunction

    function void push_output(int m, logic last);
      flc_pkg::rsp_t e;
      e.conv_out    = fir_sum(m);
      e.last_output = last;
      expected_sums.push_back(e);
    endfunction

    function void note_request(flc_pkg::req_t r);
      int m;
      n_requests++;
      if (r.func == flc_pkg::FUNC_LOAD) begin
        taps[r.tap_index] = r.sample_value;
        n_loads++;
        return;
      end
      m = taps_used();
      shift_in(r.sample_value);
      push_output(m, r.last_sample && (m == 1));
      if (r.last_sample) begin
        // flush the tail with zeros, flag the final output, then clear the line
        n_vectors++;
        for (int t = 1; t < m; t++) begin
          shift_in('0);
          push_output(m, t == m - 1);
        end
        foreach (delay_line[i]) delay_line[i] = '0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(flc_pkg::rsp_t got);
      flc_pkg::rsp_t want;
      n_results++;
      if (expected_sums.size() == 0) begin
        report($sformatf("result %0d not expected, conv_out=%0d last=%0b",
                         n_results, got.conv_out, got.last_output));
        return;
      end
      want = expected_sums.pop_front();
      if (got.conv_out !== want.conv_out)
        report($sformatf("result %0d conv_out %0d, expected %0d",
                         n_results, got.conv_out, want.conv_out));
      if (got.last_output !== want.last_output)
        report($sformatf("result %0d last_output %0b, expected %0b",
                         n_results, got.last_output, want.last_output));
    endtask

    task close_out();
      if (expected_sums.size() != 0)
        report($sformatf("%0d expected results never arrived", expected_sums.size()));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  flc_pkg::req_t            in_req_i    = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  flc_pkg::rsp_t            out_rsp_o;
  logic                     cfg_we_i    = 1'b0;
  logic [flc_pkg::KL_W-1:0] cfg_wdata_i = '0;

  conv_scoreboard sb = new();

  // Shared pacing knobs; written by the stimulus process only.
  int   gap_max   = 4;     // 0 gives a stretch with no idling on either side
  logic burst_req = 1'b0;  // toggle to ask the receiver for a long hold
  int   n_cfg     = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  full_linear_convolution_core #(
    .MAX_TAPS   (MAX_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // Receiver: random ready gaps per result, plus one long hold on request.
  // ---------------------------------------------------------------------------
  logic burst_ack = 1'b0;
  int   hold_left = 0;

  always @(posedge clk_i) begin
    int gap;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (burst_req != burst_ack) begin
      // long stall so the core fills up and drops in_ready_o
      burst_ack   <= burst_req;
      out_ready_i <= 1'b0;
      hold_left   <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) out_ready_i <= 1'b1;
    end else if (out_ready_i && out_valid_o) begin
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        hold_left   <= gap;
      end
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result monitor: values sampled at the accepting edge, before any update.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_rsp_o);
  end

  // Watchdog on handshake activity.
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks. Each is entered right after a rising edge.
  // ---------------------------------------------------------------------------
  // Valid is only lowered when a gap is drawn, so back-to-back requests keep
  // it high without a drop in the same time step.
  task automatic send_req(flc_pkg::req_t r);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(r);
  endtask

  task automatic load_tap(logic [3:0] idx, logic [15:0] val, logic last);
    flc_pkg::req_t r;
    r.func         = flc_pkg::FUNC_LOAD;
    r.tap_index    = idx;
    r.sample_value = val;
    r.last_sample  = last;   // ignored by a load
    send_req(r);
  endtask

  task automatic feed(logic [15:0] val, logic last);
    flc_pkg::req_t r;
    r.func         = flc_pkg::FUNC_SAMPLE;
    r.tap_index    = 4'($urandom_range(0, 15));  // don't care on samples
    r.sample_value = val;
    r.last_sample  = last;
    send_req(r);
  endtask

  // Drop valid, wait for every expected result, then let the core settle.
  task automatic go_idle();
    in_valid_i <= 1'b0;
    while (sb.expected_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Only called while idle.
  task automatic set_length(logic [flc_pkg::KL_W-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    sb.kernel_len = len;
    cfg_we_i <= 1'b0;
    n_cfg++;
  endtask

  // Extremes weighted up so the 36-bit sum sees full-scale products.
  function automatic logic [15:0] draw_value();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int items;
    int n_vec;
    int vec_len;
    bit open_tail;
    logic [flc_pkg::KL_W-1:0] len;

    items = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state first (m = 16, all taps zero).
    feed(16'd5, 1'b0);
    load_tap(4'd0,  16'h8000, 1'b1);
    load_tap(4'd15, 16'h7FFF, 1'b0);
    load_tap(4'd1,  16'h0001, 1'b1);
    load_tap(4'd7,  16'hFFFF, 1'b0);
    load_tap(4'd14, 16'h5555, 1'b0);
    load_tap(4'd8,  16'hAAAA, 1'b1);
    feed(16'h7FFF, 1'b0);
    feed(16'h8000, 1'b0);
    feed(16'hFFFF, 1'b1);   // full 15-output tail
    go_idle();

    // single tap: the item's own output carries the final flag
    set_length(5'd1);
    feed(16'h8000, 1'b1);
    feed(16'h7FFF, 1'b0);   // vector left open across the next write
    go_idle();

    // zero length behaves as one tap
    set_length(5'd0);
    feed(16'h0001, 1'b1);
    go_idle();

    // over-range length saturates to the store size
    set_length(5'd31);
    feed(16'h8000, 1'b0);
    feed(16'h8000, 1'b1);
    go_idle();

    // Random phases: a length write, a few tap loads, then vectors. The last
    // vector of a phase is sometimes left open so the next length applies
    // mid-vector.
    for (int ph = 0; items < RANDOM_ITEMS; ph++) begin
      go_idle();
      case (ph)
        0:       len = 5'd16;
        1:       len = 5'd17;
        2:       len = 5'd16;
        3:       len = 5'd2;
        default: len = 5'($urandom_range(0, 31));
      endcase
      set_length(len);
      gap_max <= (ph % 4 == 3) ? 0 : 4;

      repeat ($urandom_range(0, 4)) begin
        load_tap(4'($urandom_range(0, 15)), draw_value(), 1'($urandom_range(0, 1)));
        items++;
      end

      if (ph == 2) begin
        // Receiver holds off while the sender keeps offering a long vector.
        burst_req <= ~burst_req;
        for (int s = 0; s < 30; s++) begin
          feed(draw_value(), s == 29);
          items++;
        end
      end else begin
        n_vec     = $urandom_range(1, 3);
        open_tail = ($urandom_range(0, 2) == 0);
        for (int v = 0; v < n_vec; v++) begin
          vec_len = $urandom_range(1, 8);
          for (int s = 0; s < vec_len; s++) begin
            feed(draw_value(), (s == vec_len - 1) && !(open_tail && v == n_vec - 1));
            items++;
          end
        end
      end
    end

    go_idle();
    $display("Stimulus: %0d requests (%0d tap loads, %0d vectors closed), %0d length writes",
             sb.n_requests, sb.n_loads, sb.n_vectors, n_cfg);
    $display("Results: %0d compared against the predicted sums", sb.n_results);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/flc_pkg.sv
hdl/flc_ctrl.sv
hdl/flc_datapath.sv
hdl/full_linear_convolution_core.sv
bench/full_linear_convolution_core_tb.sv
